// ===== design/ffpd_pkg.sv =====
`default_nettype none

package ffpd_pkg;

  // Field name storage is fixed at eight characters by the register width.
  localparam int unsigned KEY_MAX_DEF = 8;
  localparam int unsigned KEY_BYTES   = 8;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned OQ_DEPTH    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd2;

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef logic [KEY_BYTES-1:0][7:0] key_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       body_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       field_end;
    logic       found;
  } out_word_t;

  // Results of one accepted byte: up to two decoded bytes and an end word.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic       ok0;
    logic       ok1;
    logic       last;
    logic       found;
  } res_t;

endpackage

`default_nettype wire

// ===== design/form_field_extract_percent_decode_unit.sv =====
// A decoded byte or end word is written into the output queue when its input word is taken.
// Throughput: one input word per cycle while in_ready_o is high; two or three output words
// (escape flush, end word) go into the 4-word queue, which drains one word per ready cycle.
// Input ready is high while the output queue holds at most one word.
// Reset (async, active low) clears the window, phase, escape, count and output queue;
// registers return to key 0, length 0, max_len 255.
`default_nettype none

module form_field_extract_percent_decode_unit #(
  parameter int unsigned KEY_MAX = ffpd_pkg::KEY_MAX_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire ffpd_pkg::in_word_t                     in_word_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output ffpd_pkg::out_word_t                         out_word_o,
  input  wire logic                                   cfg_we_i,
  input  wire logic [ffpd_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [ffpd_pkg::CFG_DATA_W-1:0]        cfg_wdata_i
);
  import ffpd_pkg::*;

  key_t        key_q;
  logic [3:0]  key_len_q;
  logic [15:0] max_len_q;
  logic [3:0]  len;

  logic        in_acc;
  logic        search;
  logic        match;
  logic [7:0]  cell_byte [KEY_MAX];
  logic        cell_vld  [KEY_MAX];
  logic [KEY_MAX-1:0] hit;
  res_t        res;
  logic        space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      key_len_q <= 4'd0;
      max_len_q <= 16'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_BYTES:  key_q     <= cfg_wdata_i;
        CFG_KEY_LENGTH: key_len_q <= cfg_wdata_i[3:0];
        CFG_MAX_LEN:    max_len_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign len    = (key_len_q > 4'(KEY_MAX)) ? 4'(KEY_MAX) : key_len_q;
  assign in_acc = in_valid_i && in_ready_o;

  for (genvar g = 0; g < KEY_MAX; g++) begin : g_cell
    logic [7:0] b_in;
    logic       v_in;
    if (g == 0) begin : g_head
      assign b_in = in_word_i.in_byte;
      assign v_in = 1'b1;
    end else begin : g_body
      assign b_in = cell_byte[g-1];
      assign v_in = cell_vld[g-1];
    end
    ffpd_cell #(.Idx(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_acc && search),
      .clear_i (in_acc && in_word_i.body_last),
      .byte_i  (b_in),
      .valid_i (v_in),
      .key_i   (key_q),
      .len_i   (len),
      .byte_o  (cell_byte[g]),
      .valid_o (cell_vld[g]),
      .hit_o   (hit[g])
    );
  end

  // the new byte takes the '=' place, the row holds the key before it
  assign match = (in_word_i.in_byte == CH_EQ) && (&hit);

  ffpd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (in_acc),
    .in_i      (in_word_i),
    .match_i   (match),
    .max_len_i (max_len_q),
    .search_o  (search),
    .res_o     (res)
  );

  ffpd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  assign in_ready_o = space;

  a_end_word_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.body_last |=> out_valid_o)
    else $error("end word not queued");

  a_phase_rearmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.body_last |=> search)
    else $error("search not rearmed after body end");

  a_window_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.body_last |=> !cell_vld[0])
    else $error("window not cleared after body end");

  a_stall_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output queue");

endmodule

`default_nettype wire

// ===== design/ffpd_cell.sv =====
`default_nettype none

module ffpd_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          shift_i,
  input  wire logic          clear_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic          valid_i,
  input  wire ffpd_pkg::key_t key_i,
  input  wire logic [3:0]    len_i,
  output logic [7:0]         byte_o,
  output logic               valid_o,
  output logic               hit_o
);
  import ffpd_pkg::*;

  logic [7:0] byte_q;
  logic       valid_q;
  logic [3:0] kdist;
  logic [2:0] kidx;
  logic       in_use;

  // The byte held here lines up with key character len-1-Idx once the
  // incoming byte takes the '=' slot.
  assign kdist  = len_i - 4'(Idx) - 4'd1;
  assign kidx   = kdist[2:0];
  assign in_use = 4'(Idx) < len_i;
  assign hit_o  = !in_use || (valid_q && (byte_q == key_i[kidx]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== design/ffpd_decode.sv =====
`default_nettype none

module ffpd_decode (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire ffpd_pkg::in_word_t in_i,
  input  wire logic               match_i,
  input  wire logic [15:0]        max_len_i,
  output logic                    search_o,
  output ffpd_pkg::res_t          res_o
);
  import ffpd_pkg::*;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_DECODE = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  phase_e      ph_q, ph_d;
  logic [1:0]  pc_q, pc_d;
  logic [7:0]  pd_q, pd_d;
  logic [15:0] cnt_q, cnt_d;

  logic [7:0]  c;
  logic        last;
  logic        a0v, a1v, force_done;
  logic [7:0]  a0b, a1b;
  logic        ok0, ok1, done1, done2;
  logic [15:0] cnt1, cnt2;
  logic        found;

  function automatic logic [4:0] hex_val(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) r = {1'b1, 4'(ch - 8'h30)};
    else if (ch >= 8'h61 && ch <= 8'h66) r = {1'b1, 4'(ch - 8'h57)};
    else if (ch >= 8'h41 && ch <= 8'h46) r = {1'b1, 4'(ch - 8'h37)};
    return r;
  endfunction

  function automatic logic [7:0] plain(input logic [7:0] ch);
    return (ch == CH_PLUS) ? CH_SPACE : ch;
  endfunction

  function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [4:0] h;
    logic [4:0] l;
    logic [7:0] v;
    h = hex_val(hi);
    l = hex_val(lo);
    v = 8'd0;
    if (h[4]) v = l[4] ? {h[3:0], l[3:0]} : {4'd0, h[3:0]};
    return v;
  endfunction

  assign c    = in_i.in_byte;
  assign last = in_i.body_last;

  always_comb begin
    ph_d       = ph_q;
    pc_d       = pc_q;
    pd_d       = pd_q;
    a0v        = 1'b0;
    a1v        = 1'b0;
    a0b        = CH_PCT;
    a1b        = 8'd0;
    force_done = 1'b0;

    unique case (ph_q)
      PH_SEARCH: begin
        if (match_i) begin
          ph_d = (max_len_i == 16'd0) ? PH_DONE : PH_DECODE;
        end
      end
      PH_DECODE: begin
        if (c == CH_AMP) begin
          // unfinished escape goes out literally, then the value closes
          a0v        = pc_q != 2'd0;
          a1v        = pc_q[1];
          a1b        = plain(pd_q);
          force_done = 1'b1;
          pc_d       = 2'd0;
        end else if (pc_q == 2'd1) begin
          pd_d = c;
          pc_d = 2'd2;
          a0v  = last;
          a1v  = last;
          a1b  = plain(c);
        end else if (pc_q[1]) begin
          a0v  = 1'b1;
          a0b  = hex_pair(pd_q, c);
          pc_d = 2'd0;
        end else if (c == CH_PCT) begin
          pc_d = 2'd1;
          a0v  = last;
        end else begin
          a0v = 1'b1;
          a0b = plain(c);
        end
      end
      default: ;
    endcase

    // output limit, applied word by word
    ok0   = a0v && (cnt_q < max_len_i);
    cnt1  = cnt_q + {15'd0, ok0};
    done1 = a0v && (cnt1 >= max_len_i);
    ok1   = a1v && !done1;
    cnt2  = cnt1 + {15'd0, ok1};
    done2 = ok1 && (cnt2 >= max_len_i);
    cnt_d = cnt2;
    if (done1 || done2 || force_done) begin
      ph_d = PH_DONE;
    end

    found = ph_d != PH_SEARCH;

    if (last) begin
      ph_d  = PH_SEARCH;
      pc_d  = 2'd0;
      pd_d  = 8'd0;
      cnt_d = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_SEARCH;
      pc_q  <= 2'd0;
      pd_q  <= 8'd0;
      cnt_q <= 16'd0;
    end else if (take_i) begin
      ph_q  <= ph_d;
      pc_q  <= pc_d;
      pd_q  <= pd_d;
      cnt_q <= cnt_d;
    end
  end

  assign search_o = ph_q == PH_SEARCH;

  always_comb begin
    res_o.b0    = a0b;
    res_o.b1    = a1b;
    res_o.ok0   = take_i && ok0;
    res_o.ok1   = take_i && ok1;
    res_o.last  = take_i && last;
    res_o.found = found;
  end

endmodule

`default_nettype wire

// ===== design/ffpd_outq.sv =====
`default_nettype none

module ffpd_outq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ffpd_pkg::res_t      res_i,
  output logic                     space_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ffpd_pkg::out_word_t      out_word_o
);
  import ffpd_pkg::*;

  localparam int unsigned PtrW = $clog2(OQ_DEPTH);
  localparam int unsigned CntW = $clog2(OQ_DEPTH + 1);

  out_word_t     mem_q [OQ_DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      push_n;
  logic            pop;
  out_word_t       slot [3];
  out_word_t       end_w, b0_w, b1_w;

  always_comb begin
    end_w = '{out_byte: 8'd0, has_byte: 1'b0, field_end: 1'b1, found: res_i.found};
    b0_w  = '{out_byte: res_i.b0, has_byte: 1'b1, field_end: 1'b0, found: 1'b1};
    b1_w  = '{out_byte: res_i.b1, has_byte: 1'b1, field_end: 1'b0, found: 1'b1};
    // a second byte only ever follows a first one
    slot[0] = res_i.ok0 ? b0_w : end_w;
    slot[1] = res_i.ok1 ? b1_w : end_w;
    slot[2] = end_w;
  end

  assign push_n = {1'b0, res_i.ok0} + {1'b0, res_i.ok1} + {1'b0, res_i.last};
  assign pop    = out_valid_o && out_ready_i;
  assign cnt_d  = cnt_q - CntW'(pop) + CntW'(push_n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + PtrW'(push_n);
      rptr_q <= rptr_q + PtrW'(pop);
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push_n) begin
        mem_q[wptr_q + PtrW'(k)] <= slot[k];
      end
    end
  end

  assign space_o     = cnt_q <= CntW'(OQ_DEPTH - 3);
  assign out_valid_o = cnt_q != '0;
  assign out_word_o  = mem_q[rptr_q];

endmodule

`default_nettype wire
